// File: rtl/molc_pkg.sv
// Package with types and constants shared by the occupancy light controller modules.
package molc_pkg;

    localparam int DETECTORS      = 2;
    localparam int CH_W           = (DETECTORS > 1) ? $clog2(DETECTORS) : 1;
    localparam int TICK_OVERFLOWS = 38;
    localparam int PERIOD_TICKS   = 240;
    localparam int BURST_SAMPLES  = 8;
    localparam int QDEPTH         = 4;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 13;

    localparam logic [7:0] LIGHTS_ALL = 8'hff;

    typedef enum logic [1:0] {
        OP_OVERFLOW = 2'd0,
        OP_SAMPLE   = 2'd1,
        OP_POLL     = 2'd2,
        OP_LIGHT    = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_LENGTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MOTION_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_PERIODS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_PERIODS      = 3'd4;

    typedef struct packed {
        logic [1:0] op;
        logic [9:0] sample;
        logic [7:0] light_value;
    } in_t;

    typedef struct packed {
        logic [7:0] light_pattern;
        logic       light_write;
        logic       status_report;
        logic       sampling_on;
        logic       channel;
        logic       last;
    } out_t;

    typedef struct packed {
        logic push;
        logic two;
        out_t first;
        out_t second;
    } res_t;

endpackage

// File: rtl/molc_core.sv
// Controller state, configuration registers and the per-transaction update logic.
module molc_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [molc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [molc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            item_go,
    input  molc_pkg::in_t                   item,
    output molc_pkg::res_t                  res
);
    import molc_pkg::*;

    logic [12:0] thr_reg;
    logic [7:0]  warn_len_reg;
    logic [7:0]  min_motion_reg;
    logic [7:0]  idle_per_reg;
    logic [7:0]  off_per_reg;

    logic [5:0]      ovf_reg, ovf_next;
    logic [7:0]      hsc_reg, hsc_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic            samp_en_reg, samp_en_next;
    logic [3:0]      idx_reg, idx_next;
    logic [15:0]     cur_sum_reg [DETECTORS];
    logic [15:0]     cur_sum_next [DETECTORS];
    logic [15:0]     prev_sum_reg [DETECTORS];
    logic [15:0]     prev_sum_next [DETECTORS];
    logic [7:0]      motion_reg, motion_next;
    logic [7:0]      idle_reg, idle_next;
    logic            warn_reg, warn_next;
    logic [7:0]      lights_reg, lights_next;

    logic [5:0]  ovf_inc;
    logic [15:0] cur_sel;
    logic [15:0] prev_sel;
    logic [16:0] diff;
    logic [16:0] abs_diff;
    logic [8:0]  total;
    logic [7:0]  idle_inc;
    logic        have_a;
    logic        have_b;
    logic        status_b;
    logic [7:0]  lights_a;

    assign ovf_inc  = ovf_reg + 6'd1;
    assign cur_sel  = cur_sum_reg[ch_reg];
    assign prev_sel = prev_sum_reg[ch_reg];
    assign diff     = {1'b0, cur_sel} - {1'b0, prev_sel};
    assign abs_diff = diff[16] ? (17'd0 - diff) : diff;
    assign total    = {1'b0, idle_per_reg} + {1'b0, off_per_reg};
    assign idle_inc = (motion_reg >= min_motion_reg) ? 8'd0 : (idle_reg + 8'd1);

    always_comb begin
        ovf_next      = ovf_reg;
        hsc_next      = hsc_reg;
        ch_next       = ch_reg;
        samp_en_next  = samp_en_reg;
        idx_next      = idx_reg;
        cur_sum_next  = cur_sum_reg;
        prev_sum_next = prev_sum_reg;
        motion_next   = motion_reg;
        idle_next     = idle_reg;
        warn_next     = warn_reg;
        lights_next   = lights_reg;
        have_a        = 1'b0;
        have_b        = 1'b0;
        status_b      = 1'b0;
        lights_a      = lights_reg;
        case (op_t'(item.op))
            OP_OVERFLOW: begin
                if (ovf_inc >= 6'(TICK_OVERFLOWS)) begin
                    ovf_next     = 6'd0;
                    ch_next      = (ch_reg == CH_W'(DETECTORS - 1)) ? '0 : ch_reg + 1'b1;
                    samp_en_next = 1'b1;
                    hsc_next     = hsc_reg + 8'd1;
                end else begin
                    ovf_next = ovf_inc;
                end
            end
            OP_SAMPLE: begin
                if (samp_en_reg) begin
                    if (idx_reg == 4'd0) begin
                        idx_next = 4'd1;
                    end else if (idx_reg < 4'(BURST_SAMPLES)) begin
                        cur_sum_next[ch_reg] = cur_sel + {6'd0, item.sample};
                        idx_next = idx_reg + 4'd1;
                    end else begin
                        samp_en_next = 1'b0;
                        if ((abs_diff > {4'd0, thr_reg}) && (motion_reg != 8'hff)) begin
                            motion_next = motion_reg + 8'd1;
                        end
                        prev_sum_next[ch_reg] = cur_sel;
                        cur_sum_next[ch_reg]  = 16'd0;
                        idx_next = 4'd0;
                    end
                end
            end
            OP_POLL: begin
                if (warn_reg && (hsc_reg > warn_len_reg)) begin
                    lights_next = lights_reg ^ LIGHTS_ALL;
                    lights_a    = lights_next;
                    warn_next   = 1'b0;
                    have_a      = 1'b1;
                end
                if (hsc_reg >= 8'(PERIOD_TICKS)) begin
                    idle_next = idle_inc;
                    if ({1'b0, idle_inc} == total) begin
                        lights_next = 8'd0;
                        idle_next   = 8'(total + 9'd1);
                        have_b      = 1'b1;
                        status_b    = 1'b1;
                    end else if (idle_inc == idle_per_reg) begin
                        lights_next = lights_next ^ LIGHTS_ALL;
                        warn_next   = 1'b1;
                        have_b      = 1'b1;
                    end
                    motion_next = 8'd0;
                    hsc_next    = 8'd0;
                end
            end
            OP_LIGHT: begin
                lights_next = item.light_value;
            end
            default: begin
                lights_next = lights_reg;
            end
        endcase
    end

    always_comb begin
        res.push                 = item_go;
        res.two                  = have_a && have_b;
        res.first.light_pattern  = lights_next;
        res.first.light_write    = (op_t'(item.op) == OP_LIGHT) || have_a || have_b;
        res.first.status_report  = status_b && !have_a;
        res.first.sampling_on    = samp_en_next;
        res.first.channel        = ch_next[0];
        res.first.last           = !(have_a && have_b);
        if (have_a && have_b) begin
            res.first.light_pattern = lights_a;
        end
        res.second.light_pattern = lights_next;
        res.second.light_write   = 1'b1;
        res.second.status_report = status_b;
        res.second.sampling_on   = samp_en_next;
        res.second.channel       = ch_next[0];
        res.second.last          = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= 13'd32;
            warn_len_reg   <= 8'd10;
            min_motion_reg <= 8'd1;
            idle_per_reg   <= 8'd5;
            off_per_reg    <= 8'd5;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MOTION_THRESHOLD: thr_reg        <= cfg_wdata;
                REG_WARN_LENGTH:      warn_len_reg   <= cfg_wdata[7:0];
                REG_MIN_MOTION_TICKS: min_motion_reg <= cfg_wdata[7:0];
                REG_IDLE_PERIODS:     idle_per_reg   <= cfg_wdata[7:0];
                REG_OFF_PERIODS:      off_per_reg    <= cfg_wdata[7:0];
                default: begin
                    thr_reg <= thr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_reg     <= 6'd0;
            hsc_reg     <= 8'd0;
            ch_reg      <= '0;
            samp_en_reg <= 1'b0;
            idx_reg     <= 4'd0;
            motion_reg  <= 8'd0;
            idle_reg    <= 8'd0;
            warn_reg    <= 1'b0;
            lights_reg  <= 8'd0;
            for (int i = 0; i < DETECTORS; i++) begin
                cur_sum_reg[i]  <= 16'd0;
                prev_sum_reg[i] <= 16'd0;
            end
        end else if (item_go) begin
            ovf_reg      <= ovf_next;
            hsc_reg      <= hsc_next;
            ch_reg       <= ch_next;
            samp_en_reg  <= samp_en_next;
            idx_reg      <= idx_next;
            motion_reg   <= motion_next;
            idle_reg     <= idle_next;
            warn_reg     <= warn_next;
            lights_reg   <= lights_next;
            cur_sum_reg  <= cur_sum_next;
            prev_sum_reg <= prev_sum_next;
        end
    end

endmodule

// File: rtl/molc_outq.sv
// Result queue that takes one or two results per transaction and drains one per cycle while m_ready is high.
module molc_outq (
    input  logic           aclk,
    input  logic           aresetn,
    input  molc_pkg::res_t res,
    output logic           has_room,
    output logic           m_valid,
    input  logic           m_ready,
    output molc_pkg::out_t m_data
);
    import molc_pkg::*;

    out_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              pop;
    logic [QPTR_W:0]   push_n;

    assign pop      = m_valid && m_ready;
    assign m_valid  = (cnt_reg != '0);
    assign m_data   = q_reg[rd_ptr_reg];
    assign has_room = (cnt_reg <= (QPTR_W + 1)'(QDEPTH - 2));
    assign push_n   = !res.push ? '0 : (res.two ? (QPTR_W + 1)'(2) : (QPTR_W + 1)'(1));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + push_n - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (res.push) begin
            q_reg[wr_ptr_reg] <= res.first;
            if (res.two) begin
                q_reg[wr_ptr_reg + 1'b1] <= res.second;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: rtl/motion_occupancy_light_controller_core.sv
// Top level of the motion occupancy light controller with input register and result queue.
// An accepted transaction waits in the input register until the result queue has room, then
// the core processes it and writes its results into the queue, which drives m_valid.
// Throughput: one transaction per cycle while the result queue has room; the two results of a
// poll enter the four-entry result queue together, and the queue drains them one at a time.
module motion_occupancy_light_controller_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  molc_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output molc_pkg::out_t                  m_data,
    input  logic                            cfg_wr_en,
    input  logic [molc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [molc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import molc_pkg::*;

    logic in_valid_reg;
    in_t  in_data_reg;
    logic has_room;
    logic item_go;
    res_t res;

    // Synchronous active-low aresetn clears all but the data registers and sets defaults.
    assign item_go = in_valid_reg && has_room;
    assign s_ready = !in_valid_reg || item_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    molc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item_go   (item_go),
        .item      (in_data_reg),
        .res       (res)
    );

    molc_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .has_room (has_room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// File: rtl/molc_checker.sv
// Port-level checker for the occupancy light controller and its bind to the top level.
module molc_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input molc_pkg::out_t m_data
);
    import molc_pkg::*;

    // A stalled result transaction keeps its payload.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result payload changed while stalled");

    // A switch-off always writes an all-dark pattern.
    a_status_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status_report |-> m_data.light_write && m_data.light_pattern == 8'd0)
        else $error("status report without switch-off");

    // A switch-off is always the final result of its transaction.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status_report |-> m_data.last)
        else $error("status report not on final result");

    // Only light writes can be followed by a further result of the same transaction.
    a_nowrite_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.light_write |-> m_data.last)
        else $error("non-writing result not final");

endmodule

bind motion_occupancy_light_controller_core molc_checker u_molc_checker (.*);
